>>> sv/clas_pkg.sv
package clas_pkg;

   // Weight store geometry and word formats.
   localparam int STORE_DEPTH = 2048;
   localparam int ADDR_W      = 11;
   localparam int KNOB_W      = 13;
   localparam logic [KNOB_W-1:0] KNOB_ONE   = 13'd4096;
   localparam logic [KNOB_W-1:0] KNOB_RESET = 13'd2048;

   // Request action codes.
   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_PROCESS = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;

   // Control register indexes.
   localparam logic [1:0] CSR_BASS   = 2'd0;
   localparam logic [1:0] CSR_MIDDLE = 2'd1;
   localparam logic [1:0] CSR_TREBLE = 2'd2;

   // Rounding shift applied to a product.
   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_12   = 2'd1;
   localparam logic [1:0] SH_15   = 2'd2;
   localparam logic [1:0] SH_18   = 2'd3;

   // Second operand of a streamed multiply.
   localparam logic [2:0] OPD_SAMPLE = 3'd0;
   localparam logic [2:0] OPD_BASS   = 3'd1;
   localparam logic [2:0] OPD_MIDDLE = 3'd2;
   localparam logic [2:0] OPD_TREBLE = 3'd3;
   localparam logic [2:0] OPD_HIDDEN = 3'd4;
   localparam logic [2:0] OPD_ONE    = 3'd5;
   localparam logic [2:0] OPD_EIGHT  = 3'd6;

   localparam logic [16:0] TANH_LIMIT = 17'd32746;

   typedef struct packed {
      logic [2:0] operand;
      logic [1:0] shift;
      logic       first;
      logic       last;
      logic       readout;
   } stream_ctl_type;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [2:0]  seg;
      logic [15:0] slope;
      logic [11:0] frac;
   } act_prep_type;

   // Breakpoints of tanh at steps of one half, in Q1.15.
   function automatic logic [15:0] tanh_point(input logic [3:0] k);
      logic [15:0] p;
      unique case (k)
         4'd0:    p = 16'd0;
         4'd1:    p = 16'd15143;
         4'd2:    p = 16'd24956;
         4'd3:    p = 16'd29660;
         4'd4:    p = 16'd31589;
         4'd5:    p = 16'd32329;
         4'd6:    p = 16'd32606;
         4'd7:    p = 16'd32708;
         default: p = 16'd32746;
      endcase
      return p;
   endfunction

   // First half of tanh on a Q.13 argument: magnitude, segment and slope.
   function automatic act_prep_type act_prep(input logic signed [33:0] arg);
      act_prep_type r;
      logic [33:0]  m;
      m       = arg[33] ? 34'(-arg) : arg;
      r.neg   = arg[33];
      r.sat   = |m[33:15];
      r.seg   = m[14:12];
      r.frac  = m[11:0];
      r.slope = tanh_point({1'b0, m[14:12]} + 4'd1) - tanh_point({1'b0, m[14:12]});
      return r;
   endfunction

   // Second half: add the rounded interpolation, restore the sign, map to sigmoid if asked.
   function automatic logic signed [17:0] act_finish(input act_prep_type p,
                                                     input logic [15:0] interp,
                                                     input logic is_sig);
      logic [16:0]        y;
      logic signed [17:0] ys;
      y  = p.sat ? TANH_LIMIT : {1'b0, tanh_point({1'b0, p.seg})} + {1'b0, interp};
      ys = p.neg ? -$signed({1'b0, y}) : $signed({1'b0, y});
      if (is_sig) begin
         ys = (ys + 18'sd32768) >>> 1;
      end
      return ys;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Round half up, then floor.
   function automatic logic signed [31:0] round_product(input logic signed [35:0] p,
                                                        input logic [1:0] sh);
      logic signed [35:0] r;
      unique case (sh)
         SH_NONE: r = p;
         SH_12:   r = (p + 36'sd2048) >>> 12;
         SH_15:   r = (p + 36'sd16384) >>> 15;
         default: r = (p + 36'sd131072) >>> 18;
      endcase
      return r[31:0];
   endfunction

endpackage

>>> sv/clas_if.sv
interface clas_req_if import clas_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [ADDR_W-1:0]   weight_address;
   logic signed [15:0]  weight_value;
   logic signed [15:0]  sample_in;
   modport source (output valid, action, weight_address, weight_value, sample_in,
                   input ready);
   modport sink (input valid, action, weight_address, weight_value, sample_in,
                 output ready);
endinterface

interface clas_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

interface clas_csr_if import clas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        index;
   logic [KNOB_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/clas_ram.sv
module clas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/conditioned_lstm_audio_step.sv
// One LSTM step per audio sample, with a linear readout added to the dry sample.
// The request channel carries an action: write one weight word, process a sample
// or clear the cell and hidden states. Only a process transfer gives a response,
// the saturated output sample.
// A process transfer runs on one shared 18x18 multiplier with a rounding and
// accumulate stage, fed from the weight memory read port one term per cycle
// (the first readout term waits while a previous response is still held): the
// gate preactivations, the cell and hidden update (activations reuse the
// multiplier for interpolation) and the readout, with pipeline drains. The
// request channel is not ready meanwhile.
// The control registers (the three knobs) are taken at any time on the csr
// channel but should only be written while the block is idle.
// Reset clears the cell and hidden states and sets the knobs to one half; the
// weight memory holds nothing until written. A stalled response holds in its
// output register; a following request is accepted, and its readout waits
// until the previous response has been transferred.
module conditioned_lstm_audio_step
   import clas_pkg::*;
#(
   parameter int UNITS = 16
) (
   input logic       clock,
   input logic       reset,
   clas_req_if.sink  req,
   clas_rsp_if.source rsp,
   clas_csr_if.sink  csr
);

   localparam int GATES       = 4 * UNITS;
   localparam int ROW_W       = $clog2(GATES);
   localparam int TERM_W      = $clog2(UNITS + 5);
   localparam int J_W         = (UNITS > 1) ? $clog2(UNITS) : 1;
   localparam int OFS_READOUT = 4 * GATES + GATES * UNITS + GATES;
   localparam int OFS_RB      = OFS_READOUT + UNITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_GATE  = 4'd1;
   localparam logic [3:0] ST_GWAIT = 4'd2;
   localparam logic [3:0] ST_CRD   = 4'd3;
   localparam logic [3:0] ST_CACT  = 4'd4;
   localparam logic [3:0] ST_CFIN  = 4'd5;
   localparam logic [3:0] ST_CM1   = 4'd6;
   localparam logic [3:0] ST_CM2   = 4'd7;
   localparam logic [3:0] ST_CM3   = 4'd8;
   localparam logic [3:0] ST_CM4   = 4'd9;
   localparam logic [3:0] ST_CM5   = 4'd10;
   localparam logic [3:0] ST_ROUT  = 4'd11;
   localparam logic [3:0] ST_RWAIT = 4'd12;

   logic [3:0]          state_ff;
   logic [KNOB_W-1:0]   bass_ff, middle_ff, treble_ff;
   logic signed [15:0]  hidden_ff [UNITS];
   logic signed [15:0]  cell_ff [UNITS];
   logic signed [15:0]  x_ff;
   logic [TERM_W-1:0]   t_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [J_W-1:0]      j_ff;
   logic [ROW_W-1:0]    sa_ff;
   logic [1:0]          gsel_ff;
   logic signed [17:0]  ig_ff, fg_ff, gg_ff, og_ff;
   logic signed [31:0]  t1_ff;
   act_prep_type        prep_ff;

   logic                s1_valid_ff, s2_valid_ff;
   stream_ctl_type      s1_ctl_ff, s2_ctl_ff;
   logic [ROW_W-1:0]    s1_row_ff, s2_row_ff;
   logic [J_W-1:0]      s1_j_ff;
   logic signed [35:0]  mul_ff;
   logic [1:0]          shift_ff;
   logic signed [31:0]  acc_ff;
   logic signed [15:0]  out_ff;
   logic                rsp_valid_ff;

   logic                req_fire, rsp_fire, csr_fire;
   logic                iss_valid;
   stream_ctl_type      iss_ctl;
   logic [J_W-1:0]      iss_j;
   logic [TERM_W-1:0]   t_less4, t_less1;
   logic [15:0]         wt_rdata;
   logic [31:0]         scr_rdata;
   logic [ROW_W-1:0]    scr_raddr;
   logic                scr_we;
   logic signed [17:0]  mul_a, mul_b, opd;
   logic [1:0]          mul_sh;
   logic signed [31:0]  prod_rnd, sum;
   logic signed [17:0]  act_val;
   logic signed [15:0]  c_new, h_new;
   logic signed [31:0]  gate_val;
   act_prep_type        prep_in;
   logic [KNOB_W-1:0]   kb, km, kt;
   logic                cell_phase;

   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp_valid_ff && rsp.ready;
   assign csr_fire  = csr.valid && csr.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.sample_out = out_ff;

   // Knob levels above one act as one.
   assign kb = (bass_ff > KNOB_ONE) ? KNOB_ONE : bass_ff;
   assign km = (middle_ff > KNOB_ONE) ? KNOB_ONE : middle_ff;
   assign kt = (treble_ff > KNOB_ONE) ? KNOB_ONE : treble_ff;

   // Memories: weights written by request, gate preactivations by the accumulator.
   clas_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_weights (
      .clock   (clock),
      .wr_en   (req_fire && (req.action == ACT_WRITE)),
      .wr_addr (req.weight_address),
      .wr_data (req.weight_value),
      .rd_addr (addr_ff),
      .rd_data (wt_rdata)
   );

   assign scr_we = s2_valid_ff && s2_ctl_ff.last && !s2_ctl_ff.readout;

   clas_ram #(.WIDTH(32), .DEPTH(GATES)) u_scratch (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (s2_row_ff),
      .wr_data (sum),
      .rd_addr (scr_raddr),
      .rd_data (scr_rdata)
   );

   assign scr_raddr = (state_ff == ST_CFIN) ? ROW_W'(sa_ff + ROW_W'(UNITS)) : sa_ff;

   // Term issue: a weight read per cycle, operand and rounding; readout may stall.
   assign t_less4 = t_ff - TERM_W'(4);
   assign t_less1 = t_ff - TERM_W'(1);

   always_comb begin
      iss_valid = 1'b0;
      iss_ctl   = '0;
      iss_j     = '0;
      if (state_ff == ST_GATE) begin
         iss_valid     = 1'b1;
         iss_ctl.first = (t_ff == '0);
         priority if (t_ff == '0) begin
            iss_ctl.operand = OPD_SAMPLE;
            iss_ctl.shift   = SH_15;
         end else if (t_ff == TERM_W'(1)) begin
            iss_ctl.operand = OPD_BASS;
            iss_ctl.shift   = SH_12;
         end else if (t_ff == TERM_W'(2)) begin
            iss_ctl.operand = OPD_MIDDLE;
            iss_ctl.shift   = SH_12;
         end else if (t_ff == TERM_W'(3)) begin
            iss_ctl.operand = OPD_TREBLE;
            iss_ctl.shift   = SH_12;
         end else if (t_ff == TERM_W'(UNITS + 4)) begin
            iss_ctl.operand = OPD_ONE;
            iss_ctl.shift   = SH_NONE;
            iss_ctl.last    = 1'b1;
         end else begin
            iss_ctl.operand = OPD_HIDDEN;
            iss_ctl.shift   = SH_15;
            iss_j           = t_less4[J_W-1:0];
         end
      end else if (state_ff == ST_ROUT) begin
         iss_valid       = !((t_ff == '0) && rsp_valid_ff);
         iss_ctl.readout = 1'b1;
         iss_ctl.first   = (t_ff == '0);
         iss_ctl.last    = (t_ff == TERM_W'(UNITS));
         if (t_ff == '0) begin
            iss_ctl.operand = OPD_EIGHT;
            iss_ctl.shift   = SH_NONE;
         end else begin
            iss_ctl.operand = OPD_HIDDEN;
            iss_ctl.shift   = SH_12;
            iss_j           = t_less1[J_W-1:0];
         end
      end
   end

   // Streamed operand, chosen when the weight word arrives.
   always_comb begin
      unique case (s1_ctl_ff.operand)
         OPD_SAMPLE: opd = 18'(x_ff);
         OPD_BASS:   opd = $signed({5'd0, kb});
         OPD_MIDDLE: opd = $signed({5'd0, km});
         OPD_TREBLE: opd = $signed({5'd0, kt});
         OPD_HIDDEN: opd = 18'(hidden_ff[s1_j_ff]);
         OPD_ONE:    opd = 18'sd1;
         default:    opd = 18'sd8;
      endcase
   end

   assign prod_rnd = round_product(mul_ff, shift_ff);
   assign cell_phase = (state_ff == ST_CACT) || (state_ff == ST_CM1) ||
                       (state_ff == ST_CM2) || (state_ff == ST_CM3) || (state_ff == ST_CM4);

   // Cell step operands and the activation halves around the shared multiplier.
   assign gate_val = $signed(scr_rdata);
   assign c_new    = sat16({t1_ff[31], t1_ff} + {prod_rnd[31], prod_rnd});
   assign h_new    = sat16({prod_rnd[31], prod_rnd});
   assign act_val  = act_finish(prep_ff, prod_rnd[15:0],
                                !((state_ff == ST_CFIN) && (gsel_ff == 2'd2)) &&
                                (state_ff != ST_CM4));

   always_comb begin
      prep_in = act_prep({{2{gate_val[31]}}, gate_val});
      mul_a   = 18'(signed'(wt_rdata));
      mul_b   = opd;
      mul_sh  = s1_ctl_ff.shift;
      if (state_ff == ST_CACT && gsel_ff == 2'd2) begin
         prep_in = act_prep({gate_val[31], gate_val, 1'b0});
      end else if (state_ff == ST_CM3) begin
         prep_in = act_prep({{17{c_new[15]}}, c_new, 1'b0});
      end
      if (cell_phase) begin
         unique case (state_ff)
            ST_CM1: begin
               mul_a  = fg_ff;
               mul_b  = 18'(cell_ff[j_ff]);
               mul_sh = SH_15;
            end
            ST_CM2: begin
               mul_a  = ig_ff;
               mul_b  = gg_ff;
               mul_sh = SH_18;
            end
            ST_CM4: begin
               mul_a  = og_ff;
               mul_b  = act_val;
               mul_sh = SH_15;
            end
            default: begin
               mul_a  = $signed({2'b00, prep_in.slope});
               mul_b  = $signed({6'd0, prep_in.frac});
               mul_sh = SH_12;
            end
         endcase
      end
   end

   assign sum = s2_ctl_ff.first ? prod_rnd : acc_ff + prod_rnd;

   // Multiply stage and accumulate stage; payload only.
   always_ff @(posedge clock) begin
      mul_ff    <= mul_a * mul_b;
      shift_ff  <= mul_sh;
      s1_ctl_ff <= iss_ctl;
      s1_row_ff <= row_ff;
      s1_j_ff   <= iss_j;
      s2_ctl_ff <= s1_ctl_ff;
      s2_row_ff <= s1_row_ff;
      if (s2_valid_ff) begin
         acc_ff <= sum;
      end
      if (s2_valid_ff && s2_ctl_ff.last && s2_ctl_ff.readout) begin
         out_ff <= sat16({sum[31], sum} + 33'(x_ff));
      end
      if (req_fire) begin
         x_ff <= req.sample_in;
      end
      if (state_ff == ST_CACT || state_ff == ST_CM3) begin
         prep_ff <= prep_in;
      end
      if (state_ff == ST_CM2) begin
         t1_ff <= prod_rnd;
      end
      if (state_ff == ST_CFIN) begin
         unique case (gsel_ff)
            2'd0:    ig_ff <= act_val;
            2'd1:    fg_ff <= act_val;
            2'd2:    gg_ff <= act_val;
            default: og_ff <= act_val;
         endcase
      end
   end

   // Sequencer, states and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bass_ff      <= KNOB_RESET;
         middle_ff    <= KNOB_RESET;
         treble_ff    <= KNOB_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         t_ff         <= '0;
         row_ff       <= '0;
         addr_ff      <= '0;
         j_ff         <= '0;
         sa_ff        <= '0;
         gsel_ff      <= '0;
         for (int u = 0; u < UNITS; u++) begin
            hidden_ff[u] <= '0;
            cell_ff[u]   <= '0;
         end
      end else begin
         s1_valid_ff <= iss_valid;
         s2_valid_ff <= s1_valid_ff;

         if (csr_fire) begin
            unique case (csr.index)
               CSR_BASS:   bass_ff   <= csr.data;
               CSR_MIDDLE: middle_ff <= csr.data;
               CSR_TREBLE: treble_ff <= csr.data;
               default: ;
            endcase
         end

         if (s2_valid_ff && s2_ctl_ff.last && s2_ctl_ff.readout) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req.action == ACT_PROCESS) begin
                  state_ff <= ST_GATE;
                  t_ff     <= '0;
                  row_ff   <= '0;
                  addr_ff  <= '0;
               end else if (req_fire && req.action == ACT_CLEAR) begin
                  for (int u = 0; u < UNITS; u++) begin
                     hidden_ff[u] <= '0;
                     cell_ff[u]   <= '0;
                  end
               end
            end
            ST_GATE: begin
               // Term address steps by one gate column; a new row starts one higher.
               if (t_ff == TERM_W'(UNITS + 4)) begin
                  t_ff    <= '0;
                  row_ff  <= row_ff + ROW_W'(1);
                  addr_ff <= ADDR_W'(row_ff) + ADDR_W'(1);
                  if (row_ff == ROW_W'(GATES - 1)) begin
                     state_ff <= ST_GWAIT;
                  end
               end else begin
                  t_ff    <= t_ff + TERM_W'(1);
                  addr_ff <= addr_ff + ADDR_W'(GATES);
               end
            end
            ST_GWAIT: begin
               if (!s1_valid_ff && !s2_valid_ff) begin
                  state_ff <= ST_CRD;
                  j_ff     <= '0;
                  sa_ff    <= '0;
                  gsel_ff  <= '0;
               end
            end
            ST_CRD: state_ff <= ST_CACT;
            ST_CACT: state_ff <= ST_CFIN;
            ST_CFIN: begin
               if (gsel_ff == 2'd3) begin
                  state_ff <= ST_CM1;
               end else begin
                  gsel_ff  <= gsel_ff + 2'd1;
                  sa_ff    <= ROW_W'(sa_ff + ROW_W'(UNITS));
                  state_ff <= ST_CACT;
               end
            end
            ST_CM1: state_ff <= ST_CM2;
            ST_CM2: state_ff <= ST_CM3;
            ST_CM3: begin
               cell_ff[j_ff] <= c_new;
               state_ff      <= ST_CM4;
            end
            ST_CM4: state_ff <= ST_CM5;
            ST_CM5: begin
               hidden_ff[j_ff] <= h_new;
               gsel_ff         <= '0;
               if (j_ff == J_W'(UNITS - 1)) begin
                  state_ff <= ST_ROUT;
                  t_ff     <= '0;
                  addr_ff  <= ADDR_W'(OFS_RB);
               end else begin
                  j_ff     <= j_ff + J_W'(1);
                  sa_ff    <= ROW_W'(j_ff) + ROW_W'(1);
                  state_ff <= ST_CRD;
               end
            end
            ST_ROUT: begin
               if (iss_valid) begin
                  t_ff    <= t_ff + TERM_W'(1);
                  addr_ff <= (t_ff == '0) ? ADDR_W'(OFS_READOUT) : addr_ff + ADDR_W'(1);
                  if (t_ff == TERM_W'(UNITS)) begin
                     state_ff <= ST_RWAIT;
                  end
               end
            end
            ST_RWAIT: begin
               if (!s1_valid_ff && !s2_valid_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
